/* design/btt_pkg.sv */
// ----------------------------------------------------------------------------
// btt_pkg: shared types and constants
// Widths of weights, cross products and depth, vertex register indices and the divider cell payload.
// ----------------------------------------------------------------------------
`default_nettype none

package btt_pkg;

  localparam int unsigned WeightFracBits = 16;
  localparam int unsigned CrossW         = 36;  // signed cross products (Q8, exact)
  localparam int unsigned ZW             = 24;

  localparam int unsigned RegVertexZero = 0;
  localparam int unsigned RegVertexOne  = 1;
  localparam int unsigned RegVertexTwo  = 2;

  typedef struct packed {
    logic                   valid;
    logic                   hit;
    logic                   degen;
    logic [CrossW-1:0]      den;   // |D|
  } btt_ctl_t;

endpackage

`default_nettype wire

/* design/btt_div_cell.sv */
// ----------------------------------------------------------------------------
// btt_div_cell: one restoring-division step for two quotients
// Shifts in one quotient bit of u and of v per cycle while ce is high, passes data onward.
// ----------------------------------------------------------------------------
`default_nettype none

module btt_div_cell #(
  parameter int unsigned QW = 17
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire btt_pkg::btt_ctl_t              ctl_in,
  input  wire logic [btt_pkg::CrossW:0]       rem_u_in,
  input  wire logic [btt_pkg::CrossW:0]       rem_v_in,
  input  wire logic [QW-1:0]                  q_u_in,
  input  wire logic [QW-1:0]                  q_v_in,
  input  wire logic [btt_pkg::ZW-1:0]         z0_in,
  input  wire logic [btt_pkg::ZW-1:0]         z1_in,
  input  wire logic [btt_pkg::ZW-1:0]         z2_in,
  input  wire logic                           shift_in_en,
  input  wire logic                           ce,
  output btt_pkg::btt_ctl_t                   ctl_out,
  output logic [btt_pkg::CrossW:0]            rem_u_out,
  output logic [btt_pkg::CrossW:0]            rem_v_out,
  output logic [QW-1:0]                       q_u_out,
  output logic [QW-1:0]                       q_v_out,
  output logic [btt_pkg::ZW-1:0]              z0_out,
  output logic [btt_pkg::ZW-1:0]              z1_out,
  output logic [btt_pkg::ZW-1:0]              z2_out
);
  import btt_pkg::*;

  logic [CrossW+1:0] tu, tv;
  logic [CrossW+1:0] du, dv;
  logic              gu, gv;

  // each step doubles the remainder when shift_in_en is high and tries a subtract
  always_comb begin
    tu = {rem_u_in, 1'b0};
    tv = {rem_v_in, 1'b0};
    if (!shift_in_en) begin
      tu = {1'b0, rem_u_in};
      tv = {1'b0, rem_v_in};
    end
    du = tu - {2'b00, ctl_in.den};
    dv = tv - {2'b00, ctl_in.den};
    gu = !du[CrossW+1];
    gv = !dv[CrossW+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (ce) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (ce) begin
      ctl_out.hit    <= ctl_in.hit;
      ctl_out.degen  <= ctl_in.degen;
      ctl_out.den    <= ctl_in.den;
      rem_u_out      <= gu ? du[CrossW:0] : tu[CrossW:0];
      rem_v_out      <= gv ? dv[CrossW:0] : tv[CrossW:0];
      q_u_out        <= {q_u_in[QW-2:0], gu};
      q_v_out        <= {q_v_in[QW-2:0], gv};
      z0_out         <= z0_in;
      z1_out         <= z1_in;
      z2_out         <= z2_in;
    end
  end

endmodule

`default_nettype wire

/* design/barycentric_triangle_test_unit.sv */
// ----------------------------------------------------------------------------
// barycentric_triangle_test_unit: pixel-in-triangle test with depth
// Edge functions, a chain of divider cells, then weighted depth.
// ----------------------------------------------------------------------------
// One pixel per beat, one result per pixel. The pipeline registers the edge
// products, then their sums, then the sign-normalized values; then come
// WEIGHT_FRAC_BITS + 1 divider cells producing one quotient bit each for u
// and v, then registers for the depth products and their sum, and one
// rounding and output register. The whole chain advances whenever the
// output register is empty or being taken: one beat per clock unless stalled.
`default_nettype none

module barycentric_triangle_test_unit #(
  parameter int unsigned WEIGHT_FRAC_BITS = btt_pkg::WeightFracBits
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  // slave: tdata = pixel_x[11:0], pixel_y[23:12]
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,
  // master: tdata = weight_u, weight_v, weight_w, depth (24), zero padded
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [((3*(WEIGHT_FRAC_BITS+1)+24+7)/8)*8-1:0] m_tdata,
  // master: tuser = inside_res[0], degenerate[1]
  output logic [1:0]       m_tuser
);
  import btt_pkg::*;

  localparam int unsigned QW   = WEIGHT_FRAC_BITS + 1;
  localparam int unsigned NC   = QW;
  localparam int unsigned OW   = ((3*QW+24+7)/8)*8;
  localparam int unsigned PW   = QW + ZW + 1;   // product width
  localparam int unsigned SW   = PW + 3;

  logic [55:0] vz, vo, vt;
  logic        ce;

  // configuration
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      vz <= '0; vo <= '0; vt <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:3])
        2'(RegVertexZero): vz <= pwdata[55:0];
        2'(RegVertexOne):  vo <= pwdata[55:0];
        2'(RegVertexTwo):  vt <= pwdata[55:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[4:3])
      2'(RegVertexZero): prdata = {8'd0, vz};
      2'(RegVertexOne):  prdata = {8'd0, vo};
      2'(RegVertexTwo):  prdata = {8'd0, vt};
      default:           prdata = '0;
    endcase
  end

  logic signed [17:0] x0, y0, x1, y1, x2, y2, px, py;
  assign x0 = 18'(signed'(vz[15:0]));  assign y0 = 18'(signed'(vz[31:16]));
  assign x1 = 18'(signed'(vo[15:0]));  assign y1 = 18'(signed'(vo[31:16]));
  assign x2 = 18'(signed'(vt[15:0]));  assign y2 = 18'(signed'(vt[31:16]));
  assign px = signed'({2'b00, s_tdata[11:0], 4'd0});
  assign py = signed'({2'b00, s_tdata[23:12], 4'd0});

  logic m_full;
  assign ce       = !m_full || m_tready;
  assign s_tready = ce;

  // stage 1: six products
  logic              v1;
  logic signed [35:0] pd_a, pd_b, pu_a, pu_b, pv_a, pv_b;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (ce) v1 <= s_tvalid;
    if (ce) begin
      pd_a <= (y1 - y2) * (x0 - x2);
      pd_b <= (x2 - x1) * (y0 - y2);
      pu_a <= (y1 - y2) * (px - x2);
      pu_b <= (x2 - x1) * (py - y2);
      pv_a <= (y2 - y0) * (px - x2);
      pv_b <= (x0 - x2) * (py - y2);
    end
  end

  // stage 2: sums
  logic               v2;
  logic signed [37:0] dd, nu, nv;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (ce) v2 <= v1;
    if (ce) begin
      dd <= 38'(pd_a) + 38'(pd_b);
      nu <= 38'(pu_a) + 38'(pu_b);
      nv <= 38'(pv_a) + 38'(pv_b);
    end
  end

  // stage 3: normalize sign, decide inside
  logic signed [37:0] ad, anu, anv, anw;
  always_comb begin
    ad  = dd[37] ? -dd : dd;
    anu = dd[37] ? -nu : nu;
    anv = dd[37] ? -nv : nv;
    anw = ad - anu - anv;
  end

  btt_ctl_t           c_ctl [NC+1];
  logic [CrossW:0]    c_ru  [NC+1];
  logic [CrossW:0]    c_rv  [NC+1];
  logic [QW-1:0]      c_qu  [NC+1];
  logic [QW-1:0]      c_qv  [NC+1];
  logic [ZW-1:0]      c_z0  [NC+1];
  logic [ZW-1:0]      c_z1  [NC+1];
  logic [ZW-1:0]      c_z2  [NC+1];

  logic ins3;
  assign ins3 = (dd != 0) && !anu[37] && !anv[37] && !anw[37];

  always_ff @(posedge clk) begin
    if (rst) c_ctl[0].valid <= 1'b0;
    else if (ce) c_ctl[0].valid <= v2;
    if (ce) begin
      c_ctl[0].hit    <= ins3;
      c_ctl[0].degen  <= (dd == 0);
      c_ctl[0].den    <= ins3 ? ad[CrossW-1:0] : CrossW'(1);
      c_ru[0]         <= ins3 ? anu[CrossW:0] : '0;
      c_rv[0]         <= ins3 ? anv[CrossW:0] : '0;
      c_qu[0]         <= '0;
      c_qv[0]         <= '0;
      c_z0[0]         <= vz[55:32];
      c_z1[0]         <= vo[55:32];
      c_z2[0]         <= vt[55:32];
    end
  end

  // quotient bits from 2^F down to 2^0; first cell compares unshifted numerator
  for (genvar i = 0; i < NC; i++) begin : g_cell
    btt_div_cell #(.QW(QW)) u_cell (
      .clk(clk), .rst(rst),
      .ctl_in(c_ctl[i]), .rem_u_in(c_ru[i]), .rem_v_in(c_rv[i]),
      .q_u_in(c_qu[i]), .q_v_in(c_qv[i]),
      .z0_in(c_z0[i]), .z1_in(c_z1[i]), .z2_in(c_z2[i]),
      .shift_in_en(i != 0), .ce(ce),
      .ctl_out(c_ctl[i+1]), .rem_u_out(c_ru[i+1]), .rem_v_out(c_rv[i+1]),
      .q_u_out(c_qu[i+1]), .q_v_out(c_qv[i+1]),
      .z0_out(c_z0[i+1]), .z1_out(c_z1[i+1]), .z2_out(c_z2[i+1])
    );
  end

  // depth products
  logic [QW-1:0] qu, qv, qw;
  assign qu = c_qu[NC];
  assign qv = c_qv[NC];
  assign qw = QW'((QW+1)'(1) << WEIGHT_FRAC_BITS) - qu - qv;

  logic              v5, ins5, deg5;
  logic [QW-1:0]     u5, vv5, w5;
  logic signed [PW-1:0] m0, m1, m2;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (ce) v5 <= c_ctl[NC].valid;
    if (ce) begin
      ins5 <= c_ctl[NC].hit;
      deg5 <= c_ctl[NC].degen;
      u5 <= qu; vv5 <= qv; w5 <= qw;
      m0 <= signed'({1'b0, qu}) * signed'(c_z0[NC]);
      m1 <= signed'({1'b0, qv}) * signed'(c_z1[NC]);
      m2 <= signed'({1'b0, qw}) * signed'(c_z2[NC]);
    end
  end

  logic              v6, ins6, deg6;
  logic [QW-1:0]     u6, vv6, w6;
  logic signed [SW-1:0] s6;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (ce) v6 <= v5;
    if (ce) begin
      ins6 <= ins5; deg6 <= deg5;
      u6 <= u5; vv6 <= vv5; w6 <= w5;
      s6 <= SW'(m0) + SW'(m1) + SW'(m2) + SW'(1 << (WEIGHT_FRAC_BITS - 1));
    end
  end

  // arithmetic shift is floor; then saturate
  logic signed [SW-1:0] sh;
  logic [ZW-1:0]        dep;
  always_comb begin
    sh = s6 >>> WEIGHT_FRAC_BITS;
    if (sh > SW'(8388607))        dep = 24'h7FFFFF;
    else if (sh < -SW'(8388608))  dep = 24'h800000;
    else                          dep = sh[ZW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) m_full <= 1'b0;
    else if (ce) m_full <= v6;
    if (ce) begin
      m_tuser <= {deg6, ins6};
      if (ins6) m_tdata <= OW'({dep, w6, vv6, u6});
      else      m_tdata <= '0;
    end
  end
  assign m_tvalid = m_full;

endmodule

`default_nettype wire
